// File: hdl/utf8rd_pkg.sv
package utf8rd_pkg;

	localparam int unsigned CP_W    = 21;
	localparam int unsigned LEN_W   = 3;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned TDATA_W = 24;

	localparam logic [CP_W-1:0] REPL_RESET = 21'd65533;

	// declared sequence lengths
	localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
	localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
	localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
	localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
	localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

	typedef struct packed {
		logic [CP_W-1:0]  code_point;
		logic [LEN_W-1:0] seq_length;
		logic             bad_sequence;
	} rune_t;

	// continuation byte: 10xx_xxxx
	function automatic logic is_cont(input logic [BYTE_W-1:0] b);
		is_cont = (b[7:6] == 2'b10);
	endfunction

endpackage

// File: hdl/utf8_rune_decoder.sv
// channel   | dir | contents (low bit first)                        | accepted when
// ----------+-----+-------------------------------------------------+------------------------------
// s_axis    | in  | tdata: in_byte[7:0]; tlast: end_of_buffer       | s_axis_tvalid & s_axis_tready
// m_axis    | out | tdata: code_point[20:0], seq_length[23:21];     | m_axis_tvalid & m_axis_tready
//           |     | tuser: bad_sequence                             |
// cfg       | in  | cfg_data: replacement_value[20:0]               | cfg_valid & cfg_ready
//
// one byte per cycle unless s_axis is stalled: each word updates the open-sequence state and
// at most one rune is produced into the output register on the same edge
// a rune appears on m_axis in the cycle after the word that completes it is accepted
// reset clears the sequence state and the output valid, replacement value to U+FFFD
// s_axis stalls only while a rune sits in the output register and m_axis_tready is low
module utf8_rune_decoder (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [utf8rd_pkg::BYTE_W-1:0]      s_axis_tdata,  // in_byte[7:0]
	input  logic                               s_axis_tlast,  // end_of_buffer
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [utf8rd_pkg::TDATA_W-1:0]     m_axis_tdata,  // code_point[20:0], seq_length[23:21]
	output logic                               m_axis_tuser,  // bad_sequence
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [utf8rd_pkg::CP_W-1:0]        cfg_data       // replacement_value[20:0]
);
	import utf8rd_pkg::*;

	// open-sequence state
	logic [LEN_W-1:0] exp_len_q;
	logic [LEN_W-1:0] seen_q;
	logic [CP_W-1:0]  acc_q;
	logic             bad_q;
	logic [CP_W-1:0]  repl_q;

	// output register
	logic  out_valid_q;
	rune_t out_q;

	// next values
	logic [LEN_W-1:0] exp_len_d;
	logic [LEN_W-1:0] seen_d;
	logic [CP_W-1:0]  acc_d;
	logic             bad_d;
	logic             emit;
	rune_t            rune;

	logic [BYTE_W-1:0] b;
	logic              in_acc;
	logic              out_free;
	logic [LEN_W-1:0]  remain;

	assign b         = s_axis_tdata;
	assign out_free  = !out_valid_q || m_axis_tready;
	assign s_axis_tready = out_free;
	assign in_acc    = s_axis_tvalid && out_free;
	assign cfg_ready = 1'b1;

	// digits still to come after this one, picks the 6-bit slot of the continuation
	assign remain = exp_len_q - seen_q - LEN_ONE;

	always_comb begin
		exp_len_d = exp_len_q;
		seen_d    = seen_q;
		acc_d     = acc_q;
		bad_d     = bad_q;
		emit      = 1'b0;
		rune      = '{code_point: repl_q, seq_length: LEN_ONE, bad_sequence: 1'b1};
		if (exp_len_q == LEN_NONE) begin
			priority if (!b[7]) begin
				// plain ascii
				emit = 1'b1;
				rune = '{code_point: {{(CP_W-BYTE_W){1'b0}}, b}, seq_length: LEN_ONE,
					bad_sequence: 1'b0};
			end else if (b[7:6] == 2'b10 || b[7:3] == 5'b11111) begin
				// stray continuation or impossible lead
				emit = 1'b1;
			end else begin
				seen_d = LEN_ONE;
				bad_d  = 1'b0;
				priority if (b[5] == 1'b0) begin
					exp_len_d = LEN_TWO;
					acc_d     = {10'd0, b[4:0], 6'd0};
				end else if (b[4] == 1'b0) begin
					exp_len_d = LEN_THREE;
					acc_d     = {5'd0, b[3:0], 12'd0};
				end else begin
					exp_len_d = LEN_FOUR;
					acc_d     = {b[2:0], 18'd0};
				end
				// buffer ends right after the lead
				if (s_axis_tlast) begin
					emit = 1'b1;
					rune = '{code_point: repl_q, seq_length: exp_len_d, bad_sequence: 1'b1};
					exp_len_d = LEN_NONE;
					seen_d    = LEN_NONE;
					acc_d     = '0;
				end
			end
		end else begin
			if (!is_cont(b)) begin
				bad_d = 1'b1;
			end else begin
				unique case (remain)
					3'd0:    acc_d = acc_q | {15'd0, b[5:0]};
					3'd1:    acc_d = acc_q | {9'd0, b[5:0], 6'd0};
					3'd2:    acc_d = acc_q | {3'd0, b[5:0], 12'd0};
					default: acc_d = acc_q;
				endcase
			end
			seen_d = seen_q + LEN_ONE;
			priority if (seen_d >= exp_len_q) begin
				emit = 1'b1;
				rune = '{code_point: bad_d ? repl_q : acc_d, seq_length: exp_len_q,
					bad_sequence: bad_d};
				exp_len_d = LEN_NONE;
				seen_d    = LEN_NONE;
				acc_d     = '0;
				bad_d     = 1'b0;
			end else if (s_axis_tlast) begin
				// truncated by end of buffer
				emit = 1'b1;
				rune = '{code_point: repl_q, seq_length: exp_len_q, bad_sequence: 1'b1};
				exp_len_d = LEN_NONE;
				seen_d    = LEN_NONE;
				acc_d     = '0;
				bad_d     = 1'b0;
			end else begin
				emit = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_len_q <= LEN_NONE;
			seen_q    <= LEN_NONE;
			acc_q     <= '0;
			bad_q     <= 1'b0;
		end else if (in_acc) begin
			exp_len_q <= exp_len_d;
			seen_q    <= seen_d;
			acc_q     <= acc_d;
			bad_q     <= bad_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q <= REPL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			repl_q <= cfg_data;
		end
	end

	// output register: refilled or drained whenever the consumer side is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= in_acc && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && emit) begin
			out_q <= rune;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.seq_length, out_q.code_point};
	assign m_axis_tuser  = out_q.bad_sequence;

`ifndef SYNTHESIS
	a_len_legal: assert property (@(posedge clk) disable iff (!arst_n)
		exp_len_q == LEN_NONE || exp_len_q == LEN_TWO || exp_len_q == LEN_THREE ||
		exp_len_q == LEN_FOUR)
		else $error("open sequence length out of range");

	a_seen_inside: assert property (@(posedge clk) disable iff (!arst_n)
		exp_len_q != LEN_NONE |-> (seen_q >= LEN_ONE && seen_q < exp_len_q))
		else $error("byte count escaped the open sequence");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		exp_len_q == LEN_NONE |-> (seen_q == LEN_NONE && acc_q == '0 && !bad_q))
		else $error("idle state carries leftovers");

	a_ascii_short: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.bad_sequence && out_q.seq_length == LEN_ONE |->
		out_q.code_point < 21'd128)
		else $error("single byte rune above ascii");

	a_out_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.seq_length >= LEN_ONE && out_q.seq_length <= LEN_FOUR))
		else $error("rune length out of range");
`endif

endmodule

// File: test/tb_utf8_rune_decoder.sv
module tb_utf8_rune_decoder;

	import utf8rd_pkg::*;

	// receiver hold-off used to back up the block into its input
	localparam int RX_HOLD_CYCLES = 400;
	// cycles allowed after the last rune before the run is closed
	localparam int TAIL_CYCLES = 10;
	// total random words to send
	localparam int RANDOM_WORDS = 1150;

	// expected-rune store with its own copy of the decoder state
	class rune_scoreboard;
		rune_t           expected_runes[$];
		logic [CP_W-1:0]  repl;
		logic [LEN_W-1:0] open_len;
		logic [LEN_W-1:0] seen;
		logic [CP_W-1:0]  acc;
		bit               seq_bad;
		int               errors;

		function new();
			repl = REPL_RESET;
			errors = 0;
			clear_open();
		endfunction

		function void clear_open();
			open_len = LEN_NONE;
			seen = '0;
			acc = '0;
			seq_bad = 1'b0;
		endfunction

		function void push_rune(logic [CP_W-1:0] cp, logic [LEN_W-1:0] len, logic bad);
			rune_t r;
			r.code_point = cp;
			r.seq_length = len;
			r.bad_sequence = bad;
			expected_runes.push_back(r);
		endfunction

		function void set_repl(logic [CP_W-1:0] v);
			repl = v;
		endfunction

		// next-state and rune prediction for one accepted word
		function void note_byte(logic [BYTE_W-1:0] b, logic last);
			int shift;
			logic [LEN_W-1:0] len;
			if (open_len == LEN_NONE) begin
				if (b < 8'h80) begin
					push_rune(CP_W'(b), LEN_ONE, 1'b0);
				end else if (b < 8'hC0 || b >= 8'hF8) begin
					// stray continuation or impossible lead
					push_rune(repl, LEN_ONE, 1'b1);
				end else begin
					if (b < 8'hE0) begin
						open_len = LEN_TWO;
						acc = CP_W'(b[4:0]) << 6;
					end else if (b < 8'hF0) begin
						open_len = LEN_THREE;
						acc = CP_W'(b[3:0]) << 12;
					end else begin
						open_len = LEN_FOUR;
						acc = CP_W'(b[2:0]) << 18;
					end
					seen = LEN_ONE;
					seq_bad = 1'b0;
					if (last) begin
						// lead byte alone at the end of the buffer
						len = open_len;
						clear_open();
						push_rune(repl, len, 1'b1);
					end
				end
			end else begin
				if (b[7:6] != 2'b10) begin
					// non-continuation still counts toward the declared length
					seq_bad = 1'b1;
				end else if (seen < open_len) begin
					shift = 6 * (int'(open_len) - 1 - int'(seen));
					if (shift < CP_W)
						acc = acc | (CP_W'(b[5:0]) << shift);
				end
				seen = seen + 1'b1;
				if (seen >= open_len) begin
					len = open_len;
					push_rune(seq_bad ? repl : acc, len, seq_bad);
					clear_open();
				end else if (last) begin
					// buffer ends inside the sequence
					len = open_len;
					clear_open();
					push_rune(repl, len, 1'b1);
				end
			end
		endfunction

		function void check_rune(logic [TDATA_W-1:0] data, logic bad_flag);
			rune_t want;
			logic [CP_W-1:0]  got_cp;
			logic [LEN_W-1:0] got_len;
			got_cp = data[CP_W-1:0];
			got_len = data[CP_W+LEN_W-1:CP_W];
			if (expected_runes.size() == 0) begin
				$display("%0t: unexpected rune, expected none, actual cp=%h len=%0d bad=%0b",
					$time, got_cp, got_len, bad_flag);
				errors++;
				return;
			end
			want = expected_runes.pop_front();
			if (got_cp !== want.code_point) begin
				$display("%0t: code_point expected %h actual %h", $time, want.code_point, got_cp);
				errors++;
			end
			if (got_len !== want.seq_length) begin
				$display("%0t: seq_length expected %0d actual %0d",
					$time, want.seq_length, got_len);
				errors++;
			end
			if (bad_flag !== want.bad_sequence) begin
				$display("%0t: bad_sequence expected %0b actual %0b",
					$time, want.bad_sequence, bad_flag);
				errors++;
			end
		endfunction

		function int waiting();
			return expected_runes.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [BYTE_W-1:0]   s_axis_tdata = '0;   // in_byte[7:0]
	logic                s_axis_tlast = 1'b0; // end_of_buffer
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [TDATA_W-1:0]  m_axis_tdata;        // code_point[20:0], seq_length[23:21]
	logic                m_axis_tuser;        // bad_sequence
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CP_W-1:0]     cfg_data = '0;       // replacement_value[20:0]

	// no_idle and rx_long_hold are shared between the stimulus and the receiver process; words_sent is stimulus-side
	bit no_idle = 1'b0;
	bit rx_long_hold = 1'b0;
	int words_sent = 0;

	rune_scoreboard sb = new();

	utf8_rune_decoder uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// monitors: everything is sampled at the edge, before the block's own updates land
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.set_repl(cfg_data);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_rune(m_axis_tdata, m_axis_tuser);
		end
	end

	// receiver: random stalls, plus one long hold-off on request, counted here
	initial begin
		forever begin
			if (rx_long_hold) begin
				rx_long_hold = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
			end else if (!no_idle && $urandom_range(0, 2) == 0) begin
				m_axis_tready <= 1'b0;
				repeat (pick_gap()) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// offer one word and hold it until the block takes it; valid stays up when no gap follows
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		words_sent++;
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			gap = pick_gap();
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// one random run: a well-formed sequence, a broken one, or a lone noise word
	task automatic send_random_run();
		int kind;
		int len;
		int cut;
		int i;
		logic [BYTE_W-1:0] b;
		logic last;
		kind = $urandom_range(0, 99);
		if (kind < 25) begin
			send_byte(BYTE_W'($urandom), $urandom_range(0, 7) == 0);
			return;
		end
		len = $urandom_range(1, 4);
		case (len)
			1: begin
				b = {1'b0, 7'($urandom)};
			end
			2: begin
				b = {3'b110, 5'($urandom)};
			end
			3: begin
				b = {4'b1110, 4'($urandom)};
			end
			default: begin
				b = {5'b11110, 3'($urandom)};
			end
		endcase
		// sometimes the buffer ends inside the sequence
		cut = 0;
		if (len > 1 && $urandom_range(0, 9) == 0)
			cut = $urandom_range(1, len - 1);
		for (i = 0; i < len; i++) begin
			if (i > 0)
				b = (kind < 85) ? {2'b10, 6'($urandom)} : BYTE_W'($urandom);
			last = (cut != 0) ? (i + 1 == cut) : (i == len - 1 && $urandom_range(0, 5) == 0);
			send_byte(b, last);
			if (cut != 0 && i + 1 == cut)
				break;
		end
	endtask

	// sender goes quiet until every predicted rune is out, then lets the pipe settle
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.waiting() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_repl(input logic [CP_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_phase(input int count);
		int stop_at;
		stop_at = words_sent + count;
		while (words_sent < stop_at)
			send_random_run();
	endtask

	initial begin
		int waited;
		int base;
		int i;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, every length, and the error cases, no idling
		no_idle = 1'b1;
		write_repl(21'h1FFFFF);
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h80, 1'b0);          // stray continuation
		send_byte(8'hFF, 1'b0);          // impossible lead
		send_byte(8'hF8, 1'b0);
		send_byte(8'hC0, 1'b0);          // overlong two-byte, still accepted
		send_byte(8'h80, 1'b0);
		send_byte(8'hEF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hF7, 1'b0);          // four-byte, largest value the code point field holds
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hC2, 1'b0);          // ascii inside a sequence is swallowed, marks it bad
		send_byte(8'h41, 1'b0);
		send_byte(8'hE2, 1'b0);          // truncated by end of buffer
		send_byte(8'h82, 1'b1);
		send_byte(8'hF0, 1'b1);          // lead byte is the last byte
		send_byte(8'hC3, 1'b0);          // completes exactly on the last byte
		send_byte(8'hA9, 1'b1);
		send_byte(8'h7F, 1'b1);
		no_idle = 1'b0;
		settle();

		// random with idling, replacement at zero
		write_repl(21'h000000);
		random_phase(300);
		settle();

		// random back to back, arbitrary replacement
		write_repl(CP_W'($urandom));
		no_idle = 1'b1;
		random_phase(300);
		no_idle = 1'b0;
		settle();

		// receiver holds off while the sender keeps offering, so input stalls
		write_repl(REPL_RESET);
		no_idle = 1'b1;
		rx_long_hold = 1'b1;
		base = words_sent;
		for (i = 0; i < 40; i++)
			send_byte({1'b0, 7'($urandom)}, 1'b0);
		no_idle = 1'b0;
		random_phase(150);
		// sender pauses mid-phase until every rune has come out
		settle();
		random_phase(150);
		settle();

		write_repl(21'h1FFFFF);
		random_phase(RANDOM_WORDS - (words_sent - base) - 600 + 40);
		s_axis_tvalid <= 1'b0;

		waited = 0;
		while (sb.waiting() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.waiting() != 0) begin
			$display("%0t: runes still expected %0d, actual none arrived", $time, sb.waiting());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#5000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
